// ----- src/mpsc_pkg.sv -----
// Shared types, constants and a helper function for the Mandelbrot pixel shader.
`default_nettype none
package mpsc_pkg;

  // Input request: one pixel coordinate
  typedef struct packed {
    logic [9:0] pixel_x;
    logic [9:0] pixel_y;
  } mpsc_pixel_t;

  // Result request: shade of one pixel
  typedef struct packed {
    logic       in_set;
    logic [7:0] brightness;
    logic [9:0] iteration_count;
  } mpsc_result_t;

  // Point c handed from the front end to the iteration engine
  typedef struct packed {
    logic signed [63:0] c_re;
    logic signed [63:0] c_im;
  } mpsc_point_t;

  // Configuration register indexes
  localparam logic [1:0] CFG_STEP_RE   = 2'd0;
  localparam logic [1:0] CFG_STEP_IM   = 2'd1;
  localparam logic [1:0] CFG_OFFSET_RE = 2'd2;
  localparam logic [1:0] CFG_OFFSET_IM = 2'd3;

  // Register reset values
  localparam logic [62:0] STEP_RE_RST   = 63'd211106232532992;
  localparam logic [62:0] STEP_IM_RST   = 63'd187649984473770;
  localparam logic [63:0] OFFSET_RE_RST = 64'hFF80_0000_0000_0000;
  localparam logic [63:0] OFFSET_IM_RST = 64'd0;

  // Log2 results are Q.16 with a 7-bit integer part
  localparam int unsigned LOG_W = 23;

  // Fixed-point log2 of a constant (elaboration only), Q.16
  function automatic logic [LOG_W-1:0] log2_q16_const(input logic [31:0] v);
    logic [63:0] m;
    logic [15:0] frac;
    logic [6:0]  p;
    p    = 7'd0;
    frac = 16'd0;
    for (int b = 0; b < 32; b++) begin
      if (v[b]) p = 7'(b);
    end
    m = (64'(v) << 30) >> p;
    m = m & 64'h7FFF_FFFF;
    for (int k = 0; k < 16; k++) begin
      m = (m * m) >> 30;
      frac = {frac[14:0], 1'b0};
      if (m >= 64'h8000_0000) begin
        m = m >> 1;
        frac[0] = 1'b1;
      end
    end
    return {p, frac};
  endfunction

endpackage
`default_nettype wire

// ----- src/mandelbrot_pixel_smooth_color_top.sv -----
// Top level of the Mandelbrot escape-time pixel shader with smooth coloring.
`default_nettype none
// One pixel in, one shade out. The front end maps the pixel to c in Q8.56 and
// queues it; the back end iterates z = z^2 + c on one shared 32x32 multiplier,
// 12 multiplies per round, for up to MAX_ITERATIONS rounds, then runs up to
// three log2 passes on an escaped point (each a bit-serial leading-one search
// and 16 squaring steps) and one divide. Pixels are worked one at a time in
// the back end; results wait in a two-entry output queue.
module mandelbrot_pixel_smooth_color_top #(
  parameter int unsigned MAX_ITERATIONS = 1000,
  parameter int unsigned IMAGE_WIDTH    = 1024,
  parameter int unsigned IMAGE_HEIGHT   = 768
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    cfg_we_i,
  input  wire  [1:0]             cfg_idx_i,
  input  wire  [63:0]            cfg_data_i,
  input  wire                    push,
  input  mpsc_pkg::mpsc_pixel_t  pixel_i,
  output logic                   full,
  output logic                   empty,
  input  wire                    pop,
  output mpsc_pkg::mpsc_result_t result_o
);
  import mpsc_pkg::*;

  logic          pt_valid, pt_full, pt_empty, pt_pop;
  mpsc_point_t   pt_in, pt_out;
  logic          res_full, res_push;
  mpsc_result_t  res;

  mpsc_front #(.IMAGE_WIDTH(IMAGE_WIDTH), .IMAGE_HEIGHT(IMAGE_HEIGHT)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .push       (push),
    .pixel_i    (pixel_i),
    .full       (full),
    .pt_valid_o (pt_valid),
    .pt_o       (pt_in),
    .pt_full_i  (pt_full)
  );

  // point queue between front and back
  mpsc_queue #(.T(mpsc_point_t), .DEPTH(2)) u_ptq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (pt_valid),
    .data_i  (pt_in),
    .full_o  (pt_full),
    .pop_i   (pt_pop),
    .data_o  (pt_out),
    .empty_o (pt_empty)
  );

  mpsc_core #(.MAX_ITERATIONS(MAX_ITERATIONS)) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pt_empty_i (pt_empty),
    .pt_i       (pt_out),
    .pt_pop_o   (pt_pop),
    .res_full_i (res_full),
    .res_push_o (res_push),
    .res_o      (res)
  );

  // result queue
  mpsc_queue #(.T(mpsc_result_t), .DEPTH(2)) u_resq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (result_o),
    .empty_o (empty)
  );
endmodule
`default_nettype wire

// ----- src/mpsc_queue.sv -----
// Small first-in first-out queue with full and empty flags.
`default_nettype none
module mpsc_queue #(
  parameter type T = logic [7:0],
  parameter int unsigned DEPTH = 2
) (
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  push_i,
  input  T     data_i,
  output logic full_o,
  input  wire  pop_i,
  output T     data_o,
  output logic empty_o
);
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  T               mem_q [DEPTH];
  logic [AW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [AW:0]    cnt_q, cnt_d;
  logic           do_push, do_pop;

  assign full_o  = (cnt_q == (AW+1)'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  // pointer and fill count update
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) wr_d = (wr_q == AW'(DEPTH-1)) ? '0 : wr_q + 1'b1;
    if (do_pop)  rd_d = (rd_q == AW'(DEPTH-1)) ? '0 : rd_q + 1'b1;
    if (do_push && !do_pop) cnt_d = cnt_q + 1'b1;
    if (!do_push && do_pop) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= data_i;
  end
endmodule
`default_nettype wire

// ----- src/mpsc_front.sv -----
// Front end: configuration registers and the pixel-to-point mapping.
`default_nettype none
module mpsc_front #(
  parameter int unsigned IMAGE_WIDTH  = 1024,
  parameter int unsigned IMAGE_HEIGHT = 768
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 cfg_we_i,
  input  wire  [1:0]          cfg_idx_i,
  input  wire  [63:0]         cfg_data_i,
  input  wire                 push,
  input  mpsc_pkg::mpsc_pixel_t pixel_i,
  output logic                full,
  output logic                pt_valid_o,
  output mpsc_pkg::mpsc_point_t pt_o,
  input  wire                 pt_full_i
);
  import mpsc_pkg::*;

  localparam int unsigned XW = ($clog2(IMAGE_WIDTH) > 10) ? $clog2(IMAGE_WIDTH) : 10;
  localparam int unsigned YW = ($clog2(IMAGE_HEIGHT) > 10) ? $clog2(IMAGE_HEIGHT) : 10;
  localparam int unsigned DXW = XW + 2;
  localparam int unsigned DYW = YW + 2;

  logic [62:0]  step_re_q, step_im_q;
  logic [63:0]  off_re_q, off_im_q;
  logic         v_q;
  mpsc_point_t  pt_q;
  logic         accept;

  logic signed [DXW-1:0]  dx;
  logic signed [DYW-1:0]  dy;
  logic signed [DXW+63:0] px;
  logic signed [DYW+63:0] py;
  mpsc_point_t            pt_d;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_re_q <= STEP_RE_RST;
      step_im_q <= STEP_IM_RST;
      off_re_q  <= OFFSET_RE_RST;
      off_im_q  <= OFFSET_IM_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_STEP_RE:   step_re_q <= cfg_data_i[62:0];
        CFG_STEP_IM:   step_im_q <= cfg_data_i[62:0];
        CFG_OFFSET_RE: off_re_q  <= cfg_data_i;
        CFG_OFFSET_IM: off_im_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // c = (coord - size/2) * step + offset, modulo 2^64
  always_comb begin
    dx = $signed(DXW'(pixel_i.pixel_x)) - $signed(DXW'(IMAGE_WIDTH / 2));
    dy = $signed(DYW'(pixel_i.pixel_y)) - $signed(DYW'(IMAGE_HEIGHT / 2));
    px = dx * $signed({1'b0, step_re_q});
    py = dy * $signed({1'b0, step_im_q});
    pt_d.c_re = $signed(px[63:0] + off_re_q);
    pt_d.c_im = $signed(py[63:0] + off_im_q);
  end

  // one holding stage ahead of the point queue
  assign full       = v_q && pt_full_i;
  assign accept     = push && !full;
  assign pt_valid_o = v_q;
  assign pt_o       = pt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (accept) begin
      v_q <= 1'b1;
    end else if (!pt_full_i) begin
      v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) pt_q <= pt_d;
  end
endmodule
`default_nettype wire

// ----- src/mpsc_log2.sv -----
// Multi-cycle fixed-point log2: bit-serial leading-one search, then 16 squaring steps.
`default_nettype none
module mpsc_log2 (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          start_i,
  input  wire  [127:0]                 x_i,
  output logic                         done_o,
  output logic [mpsc_pkg::LOG_W-1:0]   res_o
);
  import mpsc_pkg::*;

  localparam logic [1:0] L_IDLE = 2'd0;
  localparam logic [1:0] L_NORM = 2'd1;
  localparam logic [1:0] L_SQR  = 2'd2;

  logic [1:0]   st_q;
  logic [127:0] xs_q;
  logic [6:0]   p_q;
  logic [30:0]  m_q;
  logic [15:0]  fr_q;
  logic [3:0]   k_q;
  logic         done_q;
  logic [61:0]  sq;
  logic [31:0]  t;

  assign sq     = m_q * m_q;
  assign t      = sq[61:30];
  assign done_o = done_q;
  assign res_o  = {p_q, fr_q};

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= L_IDLE;
      done_q <= 1'b0;
      k_q    <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (st_q)
        L_IDLE: if (start_i) st_q <= L_NORM;
        L_NORM: if (xs_q[127] || p_q == '0) begin
          st_q <= L_SQR;
          k_q  <= '0;
        end
        L_SQR: begin
          k_q <= k_q + 1'b1;
          if (k_q == 4'd15) begin
            st_q   <= L_IDLE;
            done_q <= 1'b1;
          end
        end
        default: st_q <= L_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (st_q)
      L_IDLE: if (start_i) begin
        xs_q <= x_i;
        p_q  <= 7'd127;
      end
      L_NORM: begin
        if (xs_q[127] || p_q == '0) begin
          m_q  <= xs_q[127:97];
          fr_q <= '0;
        end else begin
          xs_q <= {xs_q[126:0], 1'b0};
          p_q  <= p_q - 1'b1;
        end
      end
      L_SQR: begin
        if (t[31]) begin
          m_q  <= t[31:1];
          fr_q <= {fr_q[14:0], 1'b1};
        end else begin
          m_q  <= t[30:0];
          fr_q <= {fr_q[14:0], 1'b0};
        end
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

// ----- src/mpsc_core.sv -----
// Back end: escape-time iteration on a shared 32x32 multiplier, then the shade.
`default_nettype none
module mpsc_core #(
  parameter int unsigned MAX_ITERATIONS = 1000
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    pt_empty_i,
  input  mpsc_pkg::mpsc_point_t  pt_i,
  output logic                   pt_pop_o,
  input  wire                    res_full_i,
  output logic                   res_push_o,
  output mpsc_pkg::mpsc_result_t res_o
);
  import mpsc_pkg::*;

  localparam int unsigned CW = $clog2(MAX_ITERATIONS + 1);
  localparam logic [LOG_W-1:0] LMAX_RAW = log2_q16_const(32'(MAX_ITERATIONS));
  localparam logic [23:0] LMAX = (LMAX_RAW == '0) ? 24'd1 : 24'(LMAX_RAW);

  // exact reciprocal for floor(256*la / LMAX) with la below LMAX
  localparam int unsigned DL      = $clog2(LMAX);
  localparam int unsigned RS      = 8 + 2 * DL;
  localparam logic [63:0] RECIP64 = ((64'd1 << RS) + 64'(LMAX) - 64'd1) / 64'(LMAX);
  localparam logic [31:0] RECIP   = RECIP64[31:0];

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SQ   = 4'd1;
  localparam logic [3:0] S_TEST = 4'd2;
  localparam logic [3:0] S_RI   = 4'd3;
  localparam logic [3:0] S_UPD  = 4'd4;
  localparam logic [3:0] S_LOG  = 4'd5;
  localparam logic [3:0] S_DIV  = 4'd6;
  localparam logic [3:0] S_PUSH = 4'd7;

  localparam logic [1:0] D_RR = 2'd0;
  localparam logic [1:0] D_II = 2'd1;
  localparam logic [1:0] D_RI = 2'd2;

  logic [3:0]          st_q;
  logic [3:0]          cnt_q;
  logic [1:0]          ph_q;
  logic [CW-1:0]       it_q;
  logic signed [63:0]  re_q, im_q, cre_q, cim_q;
  logic [127:0]        rr_q, ii_q, ri_q;
  logic [63:0]         prod_q;
  logic                pv_q;
  logic [1:0]          dst_q, sh_q;
  logic                in_set_q;
  logic [7:0]          br_q;
  logic [23:0]         r_q;

  logic [63:0]  mre, mim, opa, opb;
  logic [31:0]  ha, hb;
  logic         issue;
  logic [1:0]   j;
  logic [1:0]   dst;
  logic [127:0] addend;
  logic [127:0] sum;
  logic         esc;
  logic [CW-1:0] it_inc;

  logic [63:0]        rr, ii, ri, riu, dif;
  logic signed [63:0] nre, nim;

  logic                   log_start, log_done;
  logic [127:0]           log_x;
  logic [LOG_W-1:0]       log_res;
  logic signed [39:0]     lres, lm, ll, av, la;
  logic [31:0]            qnum;
  logic [63:0]            qprod;
  logic [15:0]            cnt16;

  // saturating Q8.56 add
  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] c);
    logic signed [64:0] s;
    s = {a[63], a} + {c[63], c};
    if (s[64] != s[63]) return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    return s[63:0];
  endfunction

  assign mre = re_q[63] ? 64'(-re_q) : 64'(re_q);
  assign mim = im_q[63] ? 64'(-im_q) : 64'(im_q);

  // multiplier issue: partial j of re*re, im*im or re*im
  always_comb begin
    issue = 1'b0;
    j     = cnt_q[1:0];
    dst   = D_RR;
    opa   = mre;
    opb   = mre;
    if (st_q == S_SQ && !cnt_q[3]) begin
      issue = 1'b1;
      dst   = cnt_q[2] ? D_II : D_RR;
      opa   = cnt_q[2] ? mim : mre;
      opb   = opa;
    end else if (st_q == S_RI && cnt_q[3:2] == 2'd0) begin
      issue = 1'b1;
      dst   = D_RI;
      opb   = mim;
    end
    ha = j[1] ? opa[63:32] : opa[31:0];
    hb = j[0] ? opb[63:32] : opb[31:0];
  end

  always_ff @(posedge clk_i) begin
    prod_q <= ha * hb;
    dst_q  <= dst;
    sh_q   <= 2'(j[1]) + 2'(j[0]);
  end

  assign addend = 128'(prod_q) << {sh_q, 5'd0};

  // escape test on |z|^2 against 4 (2^114 in Q16.112)
  assign sum    = rr_q + ii_q;
  assign esc    = (sum[127:115] != '0) || (sum[114] && sum[113:0] != '0);
  assign it_inc = it_q + 1'b1;

  // z update
  always_comb begin
    rr  = rr_q[119:56];
    ii  = ii_q[119:56];
    riu = ri_q[118:55];
    ri  = (re_q[63] != im_q[63]) ? 64'(-riu) : riu;
    dif = rr - ii;
    nre = sat_add($signed(dif), cre_q);
    nim = sat_add($signed(ri), cim_q);
  end

  // shade arithmetic around the log unit
  always_comb begin
    lres  = $signed(40'(log_res));
    lm    = lres - 40'sd7340032;
    ll    = lres - 40'sd1114112;
    av    = 40'sd114688 + $signed(40'({it_q, 16'd0})) - ll;
    la    = lres - 40'sd1048576;
    qnum  = {r_q, 8'd0};
    qprod = qnum * RECIP;
  end

  always_comb begin
    log_start = 1'b0;
    log_x     = sum;
    if (st_q == S_TEST && esc) begin
      log_start = 1'b1;
    end else if (st_q == S_LOG && log_done) begin
      if (ph_q == 2'd0) begin
        log_start = 1'b1;
        log_x     = 128'(lm[39:0]);
      end else if (ph_q == 2'd1 && av > 0) begin
        log_start = 1'b1;
        log_x     = 128'(av[39:0]);
      end
    end
  end

  mpsc_log2 u_log (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (log_start),
    .x_i     (log_x),
    .done_o  (log_done),
    .res_o   (log_res)
  );

  assign pt_pop_o   = (st_q == S_IDLE) && !pt_empty_i;
  assign res_push_o = (st_q == S_PUSH);
  assign cnt16      = 16'(it_q);
  assign res_o.in_set          = in_set_q;
  assign res_o.brightness      = br_q;
  assign res_o.iteration_count = cnt16[9:0];

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= S_IDLE;
      cnt_q <= '0;
      ph_q  <= '0;
      pv_q  <= 1'b0;
    end else begin
      pv_q <= issue;
      unique case (st_q)
        S_IDLE: if (!pt_empty_i) begin
          st_q  <= S_SQ;
          cnt_q <= '0;
        end
        S_SQ: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == 4'd8) st_q <= S_TEST;
        end
        S_TEST: begin
          cnt_q <= '0;
          ph_q  <= '0;
          if (esc) st_q <= S_LOG;
          else if (it_inc == CW'(MAX_ITERATIONS)) st_q <= S_PUSH;
          else st_q <= S_RI;
        end
        S_RI: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == 4'd4) st_q <= S_UPD;
        end
        S_UPD: begin
          cnt_q <= '0;
          st_q  <= S_SQ;
        end
        S_LOG: if (log_done) begin
          ph_q <= ph_q + 1'b1;
          if (ph_q == 2'd1 && !(av > 0)) st_q <= S_PUSH;
          if (ph_q == 2'd2) begin
            cnt_q <= '0;
            if (!(la > 0) || la >= $signed(40'(LMAX))) st_q <= S_PUSH;
            else st_q <= S_DIV;
          end
        end
        S_DIV: st_q <= S_PUSH;
        S_PUSH: if (!res_full_i) st_q <= S_IDLE;
        default: st_q <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (pv_q) begin
      case (dst_q)
        D_RR:    rr_q <= rr_q + addend;
        D_II:    ii_q <= ii_q + addend;
        default: ri_q <= ri_q + addend;
      endcase
    end
    case (st_q)
      S_IDLE: if (!pt_empty_i) begin
        re_q     <= pt_i.c_re;
        im_q     <= pt_i.c_im;
        cre_q    <= pt_i.c_re;
        cim_q    <= pt_i.c_im;
        it_q     <= '0;
        rr_q     <= '0;
        ii_q     <= '0;
        in_set_q <= 1'b0;
        br_q     <= '0;
      end
      S_TEST: begin
        ri_q <= '0;
        if (!esc) begin
          it_q <= it_inc;
          if (it_inc == CW'(MAX_ITERATIONS)) in_set_q <= 1'b1;
        end
      end
      S_UPD: begin
        re_q <= nre;
        im_q <= nim;
        rr_q <= '0;
        ii_q <= '0;
      end
      S_LOG: if (log_done && ph_q == 2'd2) begin
        r_q  <= la[23:0];
        if (la >= $signed(40'(LMAX))) br_q <= 8'hFF;
      end
      // quotient by reciprocal multiplication
      S_DIV: br_q <= qprod[RS +: 8];
      default: ;
    endcase
  end
endmodule
`default_nettype wire

// ----- src/mpsc_checker.sv -----
// Port-level checker for the pixel shader, bound to the top level.
`default_nettype none
module mpsc_checker #(
  parameter int unsigned MAX_ITERATIONS = 1000
) (
  input wire                    clk_i,
  input wire                    rst_ni,
  input wire                    empty,
  input wire                    pop,
  input mpsc_pkg::mpsc_result_t result_o
);
  localparam logic [15:0] MAX16 = 16'(MAX_ITERATIONS);

  // a point inside the set has no shade
  a_inset_dark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && result_o.in_set) |-> (result_o.brightness == 8'd0))
    else $error("in-set result with nonzero brightness");

  // a point inside the set reports the limit
  a_inset_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && result_o.in_set) |-> (result_o.iteration_count == MAX16[9:0]))
    else $error("in-set result with wrong iteration count");

  // nothing waits right after reset
  a_reset_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> empty)
    else $error("result present after reset");

  // a waiting result holds until taken
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(result_o)))
    else $error("waiting result changed");
endmodule

bind mandelbrot_pixel_smooth_color_top mpsc_checker #(
  .MAX_ITERATIONS(MAX_ITERATIONS)
) u_mpsc_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .empty    (empty),
  .pop      (pop),
  .result_o (result_o)
);
`default_nettype wire

// ----- tb/tb_mandelbrot_pixel_smooth_color_top.sv -----
// Testbench for the Mandelbrot pixel shader: random views and pixels checked against a predictor.
`timescale 1ns / 1ps
`default_nettype none

module tb_mandelbrot_pixel_smooth_color_top;
  import mpsc_pkg::*;

  localparam int unsigned MAX_ITER = 1000;
  localparam int unsigned IMG_W    = 1024;
  localparam int unsigned IMG_H    = 768;
  localparam longint      Q16      = 65536;

  // Holds the view registers, predicts shades and keeps the expected ones in order
  class shade_scoreboard;
    logic [62:0]  step_re;
    logic [62:0]  step_im;
    logic [63:0]  offset_re;
    logic [63:0]  offset_im;
    mpsc_result_t shade_q[$];
    int           errors;

    function new();
      step_re   = STEP_RE_RST;
      step_im   = STEP_IM_RST;
      offset_re = OFFSET_RE_RST;
      offset_im = OFFSET_IM_RST;
      errors    = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [63:0] data);
      case (idx)
        CFG_STEP_RE:   step_re = data[62:0];
        CFG_STEP_IM:   step_im = data[62:0];
        CFG_OFFSET_RE: offset_re = data;
        default:       offset_im = data;
      endcase
    endfunction

    static function logic [63:0] mag(logic [63:0] v);
      return v[63] ? -v : v;
    endfunction

    // Signed add clamped to the Q8.56 range
    static function logic [63:0] sat_add(logic [63:0] a, logic [63:0] c);
      logic signed [64:0] s;
      s = $signed({a[63], a}) + $signed({c[63], c});
      if (s > $signed(65'h0_7FFF_FFFF_FFFF_FFFF)) return 64'h7FFF_FFFF_FFFF_FFFF;
      if (s < $signed(65'h1_8000_0000_0000_0000)) return 64'h8000_0000_0000_0000;
      return s[63:0];
    endfunction

    // log2 in Q.16: leading one plus 16 bits by repeated squaring
    static function longint log2_fix(logic [127:0] v);
      int          p;
      logic [63:0] m;
      longint      fr;
      if (v == 0) return 0;
      p = 0;
      for (int b = 0; b < 128; b++) if (v[b]) p = b;
      if (p < 30) m = 64'(v << (30 - p));
      else m = 64'(v >> (p - 30));
      m  = m & 64'h7FFF_FFFF;
      fr = 0;
      for (int k = 0; k < 16; k++) begin
        m  = (m * m) >> 30;
        fr = fr << 1;
        if (m >= 64'h8000_0000) begin
          m  = m >> 1;
          fr = fr | 1;
        end
      end
      return longint'(p) * Q16 + fr;
    endfunction

    function mpsc_result_t shade(mpsc_pixel_t px);
      logic [63:0]  dx, dy, cre, cim, re, im, ar, ai, rr, ii, ri, nre;
      logic [127:0] p1, p2, p3, sq;
      int           i;
      bit           esc;
      longint       lm, ll, a, la, lmax, b;
      logic [7:0]   bright;
      mpsc_result_t r;
      dx  = 64'(px.pixel_x) - 64'(IMG_W / 2);
      dy  = 64'(px.pixel_y) - 64'(IMG_H / 2);
      cre = dx * {1'b0, step_re} + offset_re;
      cim = dy * {1'b0, step_im} + offset_im;
      re  = '0;
      im  = '0;
      sq  = '0;
      esc = 0;
      i   = 0;
      // z = z^2 + c until |z|^2 > 4
      while (i < MAX_ITER && !esc) begin
        ar = mag(re);
        ai = mag(im);
        p1 = {64'd0, ar} * {64'd0, ar};
        p2 = {64'd0, ai} * {64'd0, ai};
        p3 = {64'd0, ar} * {64'd0, ai};
        rr = p1[119:56];
        ii = p2[119:56];
        ri = p3[118:55];
        if (re[63] != im[63]) ri = -ri;
        nre = sat_add(rr - ii, cre);
        im  = sat_add(ri, cim);
        re  = nre;
        ar  = mag(re);
        ai  = mag(im);
        sq  = {64'd0, ar} * {64'd0, ar} + {64'd0, ai} * {64'd0, ai};
        if (sq > (128'd1 << 114)) esc = 1;
        else i++;
      end
      // smooth shade of an escaped point
      bright = '0;
      if (esc) begin
        lm = log2_fix(sq) - 112 * Q16;
        ll = log2_fix({64'd0, 64'(lm)}) - 17 * Q16;
        a  = 114688 + longint'(i) * Q16 - ll;
        if (a > 0) begin
          la   = log2_fix({64'd0, 64'(a)}) - 16 * Q16;
          lmax = log2_fix(128'(MAX_ITER));
          if (lmax <= 0) lmax = 1;
          if (la > 0) begin
            b      = (256 * la) / lmax;
            bright = (b > 255) ? 8'd255 : 8'(b);
          end
        end
      end
      r.in_set          = !esc;
      r.brightness      = bright;
      r.iteration_count = 10'(i);
      return r;
    endfunction

    function void note_pixel(mpsc_pixel_t px);
      shade_q.push_back(shade(px));
    endfunction

    function void check_result(mpsc_result_t got);
      mpsc_result_t want;
      if (shade_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %p", got);
        return;
      end
      want = shade_q.pop_front();
      if (got.in_set !== want.in_set || got.brightness !== want.brightness ||
          got.iteration_count !== want.iteration_count) begin
        errors++;
        if (errors <= 10) $display("mismatch: expected %p got %p", want, got);
      end
    endfunction
  endclass

  logic         clk_i;
  logic         rst_ni;
  logic         cfg_we_i;
  logic [1:0]   cfg_idx_i;
  logic [63:0]  cfg_data_i;
  logic         push;
  mpsc_pixel_t  pixel_i;
  logic         full;
  logic         empty;
  logic         pop;
  mpsc_result_t result_o;

  shade_scoreboard sb;
  bit              calm;
  int              pop_hold;

  mandelbrot_pixel_smooth_color_top i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .push       (push),
    .pixel_i    (pixel_i),
    .full       (full),
    .empty      (empty),
    .pop        (pop),
    .result_o   (result_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Timeout for the worst case, every pixel in the set
  initial begin
    #200_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Mostly short gaps, a few long ones, none during calm stretches
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(20, 150);
  endfunction

  // Result side: random pop stalls, check each accepted result
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pop && !empty) begin
        sb.check_result(result_o);
        pop_hold = pick_gap();
      end
      if (pop_hold > 0) begin
        pop_hold--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  task automatic send_pixel(logic [9:0] x, logic [9:0] y);
    int          gap;
    mpsc_pixel_t px;
    px.pixel_x = x;
    px.pixel_y = y;
    gap = pick_gap();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push    <= 1'b1;
    pixel_i <= px;
    do @(posedge clk_i); while (full);
    sb.note_pixel(px);
  endtask

  // Stop pushing and wait until every expected shade has arrived
  task automatic drain();
    push <= 1'b0;
    @(posedge clk_i);
    while (sb.shade_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic set_view(logic [63:0] sr, logic [63:0] si, logic [63:0] ofr,
                          logic [63:0] ofi);
    logic [63:0] vals [4];
    vals = '{sr, si, ofr, ofi};
    for (int k = 0; k < 4; k++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= 2'(k);
      cfg_data_i <= vals[k];
      @(posedge clk_i);
      sb.set_reg(2'(k), vals[k]);
    end
    cfg_we_i <= 1'b0;
    calm = ($urandom_range(0, 3) == 0);
  endtask

  initial begin
    logic [63:0] sr, si, ofr, ofi;
    int          kind;
    int          n;
    sb         = new();
    calm       = 0;
    pop_hold   = 0;
    rst_ni     = 1'b0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = CFG_STEP_RE;
    cfg_data_i = '0;
    push       = 1'b0;
    pixel_i    = '0;
    pop        = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset view: corners, rows beyond the image, center inside, c = -2 on the edge
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd1023, 10'd767);
    send_pixel(10'd0, 10'd767);
    send_pixel(10'd1023, 10'd0);
    send_pixel(10'd1023, 10'd1023);
    send_pixel(10'd512, 10'd384);
    send_pixel(10'd0, 10'd384);
    send_pixel(10'd1023, 10'd384);
    send_pixel(10'd300, 10'd200);
    drain();

    // Saturating extremes: huge c, shade argument at or below zero
    set_view(64'h7FFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
             64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000);
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd1023, 10'd1023);
    send_pixel(10'd512, 10'd384);
    send_pixel(10'd513, 10'd385);
    drain();

    // Zero steps: every pixel maps to the offset
    set_view(64'd0, 64'd0, 64'd0, 64'd0);
    send_pixel(10'd0, 10'd1023);
    send_pixel(10'd1023, 10'd0);
    drain();
    set_view(64'd0, 64'd0, 64'd3 << 56, 64'h8000_0000_0000_0000);
    send_pixel(10'd7, 10'd9);
    send_pixel(10'd1023, 10'd1023);
    drain();

    // Random views: raw register bits, views outside the set, views around it
    for (int ph = 0; ph < 9; ph++) begin
      kind = ph % 3;
      n    = (kind == 2) ? 35 : 80;
      if (kind == 0) begin
        sr  = {$urandom, $urandom};
        si  = {$urandom, $urandom};
        ofr = {$urandom, $urandom};
        ofi = {$urandom, $urandom};
      end else if (kind == 1) begin
        sr  = 64'($urandom_range(1, 255)) << 40;
        si  = 64'($urandom_range(1, 255)) << 40;
        ofr = 64'($urandom_range(160, 384)) << 50;
        if ($urandom_range(0, 1)) ofr = -ofr;
        ofi = 64'($urandom_range(0, 64)) << 50;
        if ($urandom_range(0, 1)) ofi = -ofi;
      end else begin
        sr  = 64'(STEP_RE_RST) + (64'($urandom_range(0, 1 << 16)) << 28);
        si  = 64'(STEP_IM_RST) + (64'($urandom_range(0, 1 << 16)) << 28);
        ofr = OFFSET_RE_RST + ((64'($urandom_range(0, 1 << 20)) - 64'(1 << 19)) << 35);
        ofi = (64'($urandom_range(0, 1 << 20)) - 64'(1 << 19)) << 34;
      end
      set_view(sr, si, ofr, ofi);
      for (int k = 0; k < n; k++) begin
        send_pixel(10'($urandom), 10'($urandom));
      end
      drain();
    end

    repeat (100) @(posedge clk_i);
    if (sb.errors == 0 && sb.shade_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ----- sim.f -----
src/mpsc_pkg.sv
src/mpsc_queue.sv
src/mpsc_front.sv
src/mpsc_log2.sv
src/mpsc_core.sv
src/mandelbrot_pixel_smooth_color_top.sv
src/mpsc_checker.sv
tb/tb_mandelbrot_pixel_smooth_color_top.sv
